>>> design/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the prime field arithmetic unit
// Field width, command codes, datapath op codes, register names and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int DW = 31;
    localparam logic [DW-1:0] MODULUS_RESET = 31'd998244353;

    // transaction command codes
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_NEG  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_INV  = 3'd4;
    localparam logic [2:0] CMD_DIV  = 3'd5;
    localparam logic [2:0] CMD_SQRT = 3'd6;

    // datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_ADD      = 4'd3;
    localparam logic [3:0] OP_SUB      = 4'd4;
    localparam logic [3:0] OP_MOV      = 4'd5;
    localparam logic [3:0] OP_EHALF    = 4'd6;
    localparam logic [3:0] OP_EMM2     = 4'd7;
    localparam logic [3:0] OP_ESHIFT   = 4'd8;
    localparam logic [3:0] OP_OUT_OK   = 4'd9;
    localparam logic [3:0] OP_OUT_FAIL = 4'd10;

    // working registers and constant sources
    localparam logic [3:0] RI_A    = 4'd0;
    localparam logic [3:0] RI_B    = 4'd1;
    localparam logic [3:0] RI_Z    = 4'd2;
    localparam logic [3:0] RI_R0   = 4'd3;
    localparam logic [3:0] RI_R1   = 4'd4;
    localparam logic [3:0] RI_B0   = 4'd5;
    localparam logic [3:0] RI_B1   = 4'd6;
    localparam logic [3:0] RI_T0   = 4'd7;
    localparam logic [3:0] RI_T1   = 4'd8;
    localparam logic [3:0] RI_T2   = 4'd9;
    localparam logic [3:0] RI_T3   = 4'd10;
    localparam logic [3:0] RI_ZERO = 4'd14;
    localparam logic [3:0] RI_ONE  = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] dst;
        logic [3:0] sx;
        logic [3:0] sy;
    } t_dp_cmd;

    typedef struct packed {
        logic eq;
        logic mul_done;
        logic e_zero;
        logic e_lsb;
        logic m_lt2;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> design/pfa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_in_if / pfa_out_if: valid/ready channels of the arithmetic unit
// Input channel carries the command and operands, output channel the result.
// ----------------------------------------------------------------------------
interface pfa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [30:0] operand_a;
    logic [30:0] operand_b;
    logic [30:0] trial_start;

    modport source (output valid, cmd, operand_a, operand_b, trial_start, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, trial_start, output ready);
endinterface

interface pfa_out_if #(parameter int VW = 31);
    logic          valid;
    logic          ready;
    logic [VW-1:0] value;
    logic          ok;

    modport source (output valid, value, ok, input ready);
    modport sink   (input valid, value, ok, output ready);
endinterface
`default_nettype wire

>>> design/prime_field_arith_sqrt_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_field_arith_sqrt_unit: prime field arithmetic with square root
// Add, sub, negate, multiply, Fermat inverse, divide and Berlekamp-Rabin
// square root modulo a programmable modulus.
// ----------------------------------------------------------------------------
// One transaction at a time. Every modular multiply runs on a single shared
// bit-serial multiplier; operand reduction costs three of them up front.
// Inverse and divide add a Fermat power to m-2, divide one more multiply.
// Square root adds the Euler power to (m-1)/2, and per candidate a power
// to (m-1)/2 in F[x]/(x^2 - a), plus one inverse when that power gives the
// root; the number of candidates is capped at MAX_TRIALS. A finished result
// sits in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module prime_field_arith_sqrt_unit #(
    parameter int MAX_TRIALS  = 64,
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    pfa_in_if.sink                      i_in,
    pfa_out_if.source                   o_res,
    input  wire logic                   i_cfg_we,
    input  wire logic [pfa_pkg::DW-1:0] i_cfg_wdata
);
    import pfa_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pfa_ctrl #(.MAX_TRIALS(MAX_TRIALS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_cmd    (i_in.cmd),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pfa_dp #(.VW(VALUE_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_a      (i_in.operand_a),
        .i_in_b      (i_in.operand_b),
        .i_in_s      (i_in.trial_start),
        .o_out_value (o_res.value),
        .o_out_ok    (o_res.ok)
    );

endmodule
`default_nettype wire

>>> design/pfa_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_mulmod: bit-serial modular multiplier
// Computes (x * y) mod m, one bit of x per cycle, MSB first; y must be < m.
// ----------------------------------------------------------------------------
module pfa_mulmod (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [pfa_pkg::DW-1:0] i_x,
    input  wire logic [pfa_pkg::DW-1:0] i_y,
    input  wire logic [pfa_pkg::DW-1:0] i_m,
    output logic                     o_done,
    output logic [pfa_pkg::DW-1:0]   o_prod
);
    import pfa_pkg::*;

    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] n_acc;
    logic [DW+1:0] w_t;
    logic [DW+1:0] w_m1;
    logic [DW+1:0] w_m2;
    logic [DW+1:0] w_s;

    // acc = (2*acc + bit*y) mod m, sum stays below 3m
    always_comb begin
        w_m1 = {2'b00, i_m};
        w_m2 = {1'b0, i_m, 1'b0};
        w_t  = {1'b0, r_acc, 1'b0} + (r_x[DW-1] ? {2'b00, r_y} : '0);
        if (w_t >= w_m2) begin
            w_s = w_t - w_m2;
        end else if (w_t >= w_m1) begin
            w_s = w_t - w_m1;
        end else begin
            w_s = w_t;
        end
        n_acc = w_s[DW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[DW-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

>>> design/pfa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_dp: datapath of the arithmetic unit
// Modulus register, working registers, modular add/sub, the shared
// multiplier, exponent shifter and the result register.
// ----------------------------------------------------------------------------
module pfa_dp #(
    parameter int VW = 31
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire pfa_pkg::t_dp_cmd       i_cmd,
    output pfa_pkg::t_dp_sts            o_sts,
    input  wire logic                   i_cfg_we,
    input  wire logic [pfa_pkg::DW-1:0] i_cfg_wdata,
    input  wire logic [pfa_pkg::DW-1:0] i_in_a,
    input  wire logic [pfa_pkg::DW-1:0] i_in_b,
    input  wire logic [pfa_pkg::DW-1:0] i_in_s,
    output logic [VW-1:0]               o_out_value,
    output logic                        o_out_ok
);
    import pfa_pkg::*;

    logic [DW-1:0] r_modulus;
    logic [DW-1:0] r_a, r_b, r_z, r_r0, r_r1, r_b0, r_b1;
    logic [DW-1:0] r_t0, r_t1, r_t2, r_t3;
    logic [DW-1:0] r_exp;
    logic [3:0]    r_mul_dst;
    logic [DW-1:0] r_out_val;
    logic          r_out_ok;

    logic [DW-1:0] w_vx, w_vy;
    logic [DW:0]   w_sum, w_diff;
    logic [DW-1:0] w_add, w_sub;
    logic          w_wen;
    logic [3:0]    w_wdst;
    logic [DW-1:0] w_wdata;
    logic          w_mul_done;
    logic [DW-1:0] w_mul_prod;
    logic [DW-1:0] w_half;
    logic [63:0]   w_ext;

    // source selects
    always_comb begin
        unique case (i_cmd.sx)
            RI_A:    w_vx = r_a;
            RI_B:    w_vx = r_b;
            RI_Z:    w_vx = r_z;
            RI_R0:   w_vx = r_r0;
            RI_R1:   w_vx = r_r1;
            RI_B0:   w_vx = r_b0;
            RI_B1:   w_vx = r_b1;
            RI_T0:   w_vx = r_t0;
            RI_T1:   w_vx = r_t1;
            RI_T2:   w_vx = r_t2;
            RI_T3:   w_vx = r_t3;
            RI_ONE:  w_vx = DW'(1);
            default: w_vx = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.sy)
            RI_A:    w_vy = r_a;
            RI_B:    w_vy = r_b;
            RI_Z:    w_vy = r_z;
            RI_R0:   w_vy = r_r0;
            RI_R1:   w_vy = r_r1;
            RI_B0:   w_vy = r_b0;
            RI_B1:   w_vy = r_b1;
            RI_T0:   w_vy = r_t0;
            RI_T1:   w_vy = r_t1;
            RI_T2:   w_vy = r_t2;
            RI_T3:   w_vy = r_t3;
            RI_ONE:  w_vy = DW'(1);
            default: w_vy = '0;
        endcase
    end

    // modular add and subtract of reduced values
    always_comb begin
        w_sum  = {1'b0, w_vx} + {1'b0, w_vy};
        w_add  = (w_sum >= {1'b0, r_modulus}) ? DW'(w_sum - {1'b0, r_modulus})
                                              : w_sum[DW-1:0];
        w_diff = {1'b0, w_vx} - {1'b0, w_vy}
               + ((w_vx < w_vy) ? {1'b0, r_modulus} : '0);
        w_sub  = w_diff[DW-1:0];
    end

    pfa_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_MUL),
        .i_x     (w_vx),
        .i_y     (w_vy),
        .i_m     (r_modulus),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // write-back select
    always_comb begin
        w_wen   = 1'b0;
        w_wdst  = i_cmd.dst;
        w_wdata = '0;
        if (w_mul_done) begin
            w_wen   = 1'b1;
            w_wdst  = r_mul_dst;
            w_wdata = w_mul_prod;
        end else begin
            case (i_cmd.op)
                OP_ADD: begin
                    w_wen   = 1'b1;
                    w_wdata = w_add;
                end
                OP_SUB: begin
                    w_wen   = 1'b1;
                    w_wdata = w_sub;
                end
                OP_MOV: begin
                    w_wen   = 1'b1;
                    w_wdata = w_vx;
                end
                default: begin
                    w_wen = 1'b0;
                end
            endcase
        end
    end

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    assign w_half = (r_modulus - DW'(1)) >> 1;

    // working registers, exponent and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL) begin
            r_mul_dst <= i_cmd.dst;
        end
        if (i_cmd.op == OP_LOAD) begin
            r_a <= i_in_a;
            r_b <= i_in_b;
            r_z <= i_in_s;
        end else if (w_wen) begin
            unique case (w_wdst)
                RI_A:    r_a  <= w_wdata;
                RI_B:    r_b  <= w_wdata;
                RI_Z:    r_z  <= w_wdata;
                RI_R0:   r_r0 <= w_wdata;
                RI_R1:   r_r1 <= w_wdata;
                RI_B0:   r_b0 <= w_wdata;
                RI_B1:   r_b1 <= w_wdata;
                RI_T0:   r_t0 <= w_wdata;
                RI_T1:   r_t1 <= w_wdata;
                RI_T2:   r_t2 <= w_wdata;
                RI_T3:   r_t3 <= w_wdata;
                default: r_t3 <= r_t3;
            endcase
        end
        case (i_cmd.op)
            OP_EHALF:  r_exp <= w_half;
            OP_EMM2:   r_exp <= r_modulus - DW'(2);
            OP_ESHIFT: r_exp <= r_exp >> 1;
            default:   r_exp <= r_exp;
        endcase
        if (i_cmd.op == OP_OUT_OK) begin
            r_out_val <= w_vx;
            r_out_ok  <= 1'b1;
        end else if (i_cmd.op == OP_OUT_FAIL) begin
            r_out_val <= '0;
            r_out_ok  <= 1'b0;
        end
    end

    // status to controller
    assign o_sts.eq       = (w_vx == w_vy);
    assign o_sts.mul_done = w_mul_done;
    assign o_sts.e_zero   = (r_exp == '0);
    assign o_sts.e_lsb    = r_exp[0];
    assign o_sts.m_lt2    = (r_modulus < DW'(2));

    assign w_ext       = {{(64 - DW){1'b0}}, r_out_val};
    assign o_out_value = w_ext[VW-1:0];
    assign o_out_ok    = r_out_ok;

endmodule
`default_nettype wire

>>> design/pfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl: controller of the arithmetic unit
// Sequences reduction, field operations, Fermat powers and the
// Berlekamp-Rabin square root search over the datapath.
// ----------------------------------------------------------------------------
module pfa_ctrl #(
    parameter int MAX_TRIALS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [2:0]       i_in_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output pfa_pkg::t_dp_cmd      o_cmd,
    input  wire pfa_pkg::t_dp_sts i_sts
);
    import pfa_pkg::*;

    localparam int TW = $clog2(MAX_TRIALS + 1);

    localparam logic [5:0] S_IDLE     = 6'd0;
    localparam logic [5:0] S_RED_A    = 6'd1;
    localparam logic [5:0] S_RED_B    = 6'd2;
    localparam logic [5:0] S_RED_Z    = 6'd3;
    localparam logic [5:0] S_DISP     = 6'd4;
    localparam logic [5:0] S_ADD      = 6'd5;
    localparam logic [5:0] S_SUB      = 6'd6;
    localparam logic [5:0] S_NEG      = 6'd7;
    localparam logic [5:0] S_MUL      = 6'd8;
    localparam logic [5:0] S_DIV2     = 6'd9;
    localparam logic [5:0] S_SQ_ZCHK  = 6'd10;
    localparam logic [5:0] S_ZERO     = 6'd11;
    localparam logic [5:0] S_EULER    = 6'd12;
    localparam logic [5:0] S_TRIAL    = 6'd13;
    localparam logic [5:0] S_TCHK     = 6'd14;
    localparam logic [5:0] S_ROOT     = 6'd15;
    localparam logic [5:0] S_RS_R0    = 6'd16;
    localparam logic [5:0] S_RS_R1    = 6'd17;
    localparam logic [5:0] S_RS_B0    = 6'd18;
    localparam logic [5:0] S_RS_B1    = 6'd19;
    localparam logic [5:0] S_RS_E     = 6'd20;
    localparam logic [5:0] S_RL_TEST  = 6'd21;
    localparam logic [5:0] S_RM1      = 6'd22;
    localparam logic [5:0] S_RM2      = 6'd23;
    localparam logic [5:0] S_RM3      = 6'd24;
    localparam logic [5:0] S_RM4      = 6'd25;
    localparam logic [5:0] S_RM5      = 6'd26;
    localparam logic [5:0] S_RM6      = 6'd27;
    localparam logic [5:0] S_RM7      = 6'd28;
    localparam logic [5:0] S_SQ1      = 6'd29;
    localparam logic [5:0] S_SQ2      = 6'd30;
    localparam logic [5:0] S_SQ3      = 6'd31;
    localparam logic [5:0] S_SQ4      = 6'd32;
    localparam logic [5:0] S_SQ5      = 6'd33;
    localparam logic [5:0] S_SQ6      = 6'd34;
    localparam logic [5:0] S_RL_SHIFT = 6'd35;
    localparam logic [5:0] S_R1CHK    = 6'd36;
    localparam logic [5:0] S_NEXTZ    = 6'd37;
    localparam logic [5:0] S_PW_INIT0 = 6'd38;
    localparam logic [5:0] S_PW_INIT1 = 6'd39;
    localparam logic [5:0] S_PW_E     = 6'd40;
    localparam logic [5:0] S_PW_TEST  = 6'd41;
    localparam logic [5:0] S_PW_MUL   = 6'd42;
    localparam logic [5:0] S_PW_SQ    = 6'd43;
    localparam logic [5:0] S_PW_SHIFT = 6'd44;
    localparam logic [5:0] S_FIN_OK   = 6'd45;
    localparam logic [5:0] S_FIN_FAIL = 6'd46;

    logic [5:0]    r_state, n_state, w_target;
    logic          r_busy, n_busy;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_cmd, n_cmd;
    logic [TW-1:0] r_trial, n_trial;
    logic [3:0]    r_pw_src, n_pw_src;
    logic          r_pw_half, n_pw_half;
    logic [5:0]    r_ret, n_ret;
    t_dp_cmd       w_c;

    // per-state command and successor
    always_comb begin
        w_c         = '{op: OP_NOP, dst: RI_T0, sx: RI_ZERO, sy: RI_ZERO};
        w_target    = r_state;
        n_cmd       = r_cmd;
        n_trial     = r_trial;
        n_pw_src    = r_pw_src;
        n_pw_half   = r_pw_half;
        n_ret       = r_ret;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_c.op   = OP_LOAD;
                    n_cmd    = i_in_cmd;
                    w_target = i_sts.m_lt2 ? S_FIN_FAIL : S_RED_A;
                end
            end
            S_RED_A: begin
                w_c      = '{op: OP_MUL, dst: RI_A, sx: RI_A, sy: RI_ONE};
                w_target = S_RED_B;
            end
            S_RED_B: begin
                w_c      = '{op: OP_MUL, dst: RI_B, sx: RI_B, sy: RI_ONE};
                w_target = S_RED_Z;
            end
            S_RED_Z: begin
                w_c      = '{op: OP_MUL, dst: RI_Z, sx: RI_Z, sy: RI_ONE};
                w_target = S_DISP;
            end
            S_DISP: begin
                case (r_cmd)
                    CMD_ADD: w_target = S_ADD;
                    CMD_SUB: w_target = S_SUB;
                    CMD_NEG: w_target = S_NEG;
                    CMD_MUL: w_target = S_MUL;
                    CMD_INV: begin
                        n_pw_src  = RI_A;
                        n_pw_half = 1'b0;
                        n_ret     = S_FIN_OK;
                        w_target  = S_PW_INIT0;
                    end
                    CMD_DIV: begin
                        n_pw_src  = RI_B;
                        n_pw_half = 1'b0;
                        n_ret     = S_DIV2;
                        w_target  = S_PW_INIT0;
                    end
                    CMD_SQRT: w_target = S_SQ_ZCHK;
                    default:  w_target = S_FIN_FAIL;
                endcase
            end
            S_ADD: begin
                w_c      = '{op: OP_ADD, dst: RI_T0, sx: RI_A, sy: RI_B};
                w_target = S_FIN_OK;
            end
            S_SUB: begin
                w_c      = '{op: OP_SUB, dst: RI_T0, sx: RI_A, sy: RI_B};
                w_target = S_FIN_OK;
            end
            S_NEG: begin
                w_c      = '{op: OP_SUB, dst: RI_T0, sx: RI_ZERO, sy: RI_A};
                w_target = S_FIN_OK;
            end
            S_MUL: begin
                w_c      = '{op: OP_MUL, dst: RI_T0, sx: RI_A, sy: RI_B};
                w_target = S_FIN_OK;
            end
            S_DIV2: begin
                w_c      = '{op: OP_MUL, dst: RI_T0, sx: RI_A, sy: RI_T0};
                w_target = S_FIN_OK;
            end
            // square root of zero is zero
            S_SQ_ZCHK: begin
                w_c.sx = RI_A;
                w_c.sy = RI_ZERO;
                if (i_sts.eq) begin
                    w_target = S_ZERO;
                end else begin
                    n_pw_src  = RI_A;
                    n_pw_half = 1'b1;
                    n_ret     = S_EULER;
                    w_target  = S_PW_INIT0;
                end
            end
            S_ZERO: begin
                w_c      = '{op: OP_MOV, dst: RI_T0, sx: RI_ZERO, sy: RI_ZERO};
                w_target = S_FIN_OK;
            end
            // Euler criterion
            S_EULER: begin
                w_c.sx = RI_T0;
                w_c.sy = RI_ONE;
                if (i_sts.eq) begin
                    n_trial  = '0;
                    w_target = S_TRIAL;
                end else begin
                    w_target = S_FIN_FAIL;
                end
            end
            S_TRIAL: begin
                w_c      = '{op: OP_MUL, dst: RI_T0, sx: RI_Z, sy: RI_Z};
                w_target = S_TCHK;
            end
            S_TCHK: begin
                w_c.sx   = RI_T0;
                w_c.sy   = RI_A;
                w_target = i_sts.eq ? S_ROOT : S_RS_R0;
            end
            S_ROOT: begin
                w_c      = '{op: OP_MOV, dst: RI_T0, sx: RI_Z, sy: RI_ZERO};
                w_target = S_FIN_OK;
            end
            // ring power setup: r = 1, base = z + x
            S_RS_R0: begin
                w_c      = '{op: OP_MOV, dst: RI_R0, sx: RI_ONE, sy: RI_ZERO};
                w_target = S_RS_R1;
            end
            S_RS_R1: begin
                w_c      = '{op: OP_MOV, dst: RI_R1, sx: RI_ZERO, sy: RI_ZERO};
                w_target = S_RS_B0;
            end
            S_RS_B0: begin
                w_c      = '{op: OP_MOV, dst: RI_B0, sx: RI_Z, sy: RI_ZERO};
                w_target = S_RS_B1;
            end
            S_RS_B1: begin
                w_c      = '{op: OP_MOV, dst: RI_B1, sx: RI_ONE, sy: RI_ZERO};
                w_target = S_RS_E;
            end
            S_RS_E: begin
                w_c.op   = OP_EHALF;
                w_target = S_RL_TEST;
            end
            S_RL_TEST: begin
                if (i_sts.e_zero) begin
                    w_target = S_R1CHK;
                end else if (i_sts.e_lsb) begin
                    w_target = S_RM1;
                end else begin
                    w_target = S_SQ1;
                end
            end
            // r = r * base in F[x]/(x^2 - a)
            S_RM1: begin
                w_c      = '{op: OP_MUL, dst: RI_T0, sx: RI_R0, sy: RI_B0};
                w_target = S_RM2;
            end
            S_RM2: begin
                w_c      = '{op: OP_MUL, dst: RI_T1, sx: RI_R1, sy: RI_B1};
                w_target = S_RM3;
            end
            S_RM3: begin
                w_c      = '{op: OP_MUL, dst: RI_T1, sx: RI_T1, sy: RI_A};
                w_target = S_RM4;
            end
            S_RM4: begin
                w_c      = '{op: OP_MUL, dst: RI_T2, sx: RI_R0, sy: RI_B1};
                w_target = S_RM5;
            end
            S_RM5: begin
                w_c      = '{op: OP_MUL, dst: RI_T3, sx: RI_R1, sy: RI_B0};
                w_target = S_RM6;
            end
            S_RM6: begin
                w_c      = '{op: OP_ADD, dst: RI_R0, sx: RI_T0, sy: RI_T1};
                w_target = S_RM7;
            end
            S_RM7: begin
                w_c      = '{op: OP_ADD, dst: RI_R1, sx: RI_T2, sy: RI_T3};
                w_target = S_SQ1;
            end
            // base = base^2
            S_SQ1: begin
                w_c      = '{op: OP_MUL, dst: RI_T0, sx: RI_B0, sy: RI_B0};
                w_target = S_SQ2;
            end
            S_SQ2: begin
                w_c      = '{op: OP_MUL, dst: RI_T1, sx: RI_B1, sy: RI_B1};
                w_target = S_SQ3;
            end
            S_SQ3: begin
                w_c      = '{op: OP_MUL, dst: RI_T1, sx: RI_T1, sy: RI_A};
                w_target = S_SQ4;
            end
            S_SQ4: begin
                w_c      = '{op: OP_MUL, dst: RI_T2, sx: RI_B0, sy: RI_B1};
                w_target = S_SQ5;
            end
            S_SQ5: begin
                w_c      = '{op: OP_ADD, dst: RI_B0, sx: RI_T0, sy: RI_T1};
                w_target = S_SQ6;
            end
            S_SQ6: begin
                w_c      = '{op: OP_ADD, dst: RI_B1, sx: RI_T2, sy: RI_T2};
                w_target = S_RL_SHIFT;
            end
            S_RL_SHIFT: begin
                w_c.op   = OP_ESHIFT;
                w_target = S_RL_TEST;
            end
            // nonzero x coefficient gives the root as its inverse
            S_R1CHK: begin
                w_c.sx = RI_R1;
                w_c.sy = RI_ZERO;
                if (!i_sts.eq) begin
                    n_pw_src  = RI_R1;
                    n_pw_half = 1'b0;
                    n_ret     = S_FIN_OK;
                    w_target  = S_PW_INIT0;
                end else begin
                    w_target = S_NEXTZ;
                end
            end
            S_NEXTZ: begin
                w_c = '{op: OP_ADD, dst: RI_Z, sx: RI_Z, sy: RI_ONE};
                if (r_trial == TW'(MAX_TRIALS - 1)) begin
                    w_target = S_FIN_FAIL;
                end else begin
                    n_trial  = r_trial + 1'b1;
                    w_target = S_TRIAL;
                end
            end
            // T0 = src ^ e, square and multiply
            S_PW_INIT0: begin
                w_c      = '{op: OP_MOV, dst: RI_T0, sx: RI_ONE, sy: RI_ZERO};
                w_target = S_PW_INIT1;
            end
            S_PW_INIT1: begin
                w_c      = '{op: OP_MOV, dst: RI_T1, sx: r_pw_src, sy: RI_ZERO};
                w_target = S_PW_E;
            end
            S_PW_E: begin
                w_c.op   = r_pw_half ? OP_EHALF : OP_EMM2;
                w_target = S_PW_TEST;
            end
            S_PW_TEST: begin
                if (i_sts.e_zero) begin
                    w_target = r_ret;
                end else if (i_sts.e_lsb) begin
                    w_target = S_PW_MUL;
                end else begin
                    w_target = S_PW_SQ;
                end
            end
            S_PW_MUL: begin
                w_c      = '{op: OP_MUL, dst: RI_T0, sx: RI_T0, sy: RI_T1};
                w_target = S_PW_SQ;
            end
            S_PW_SQ: begin
                w_c      = '{op: OP_MUL, dst: RI_T1, sx: RI_T1, sy: RI_T1};
                w_target = S_PW_SHIFT;
            end
            S_PW_SHIFT: begin
                w_c.op   = OP_ESHIFT;
                w_target = S_PW_TEST;
            end
            // result register, waits while the previous result is unread
            S_FIN_OK: begin
                if (!r_out_valid || i_out_ready) begin
                    w_c.op      = OP_OUT_OK;
                    w_c.sx      = RI_T0;
                    n_out_valid = 1'b1;
                    w_target    = S_IDLE;
                end
            end
            S_FIN_FAIL: begin
                if (!r_out_valid || i_out_ready) begin
                    w_c.op      = OP_OUT_FAIL;
                    n_out_valid = 1'b1;
                    w_target    = S_IDLE;
                end
            end
            default: begin
                w_target = S_IDLE;
            end
        endcase
    end

    // multiplies: issue once, hold state until done
    always_comb begin
        o_cmd   = w_c;
        n_busy  = r_busy;
        n_state = w_target;
        if (w_c.op == OP_MUL) begin
            if (!r_busy) begin
                n_busy  = 1'b1;
                n_state = r_state;
            end else begin
                o_cmd.op = OP_NOP;
                if (i_sts.mul_done) begin
                    n_busy = 1'b0;
                end else begin
                    n_state = r_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmd       <= CMD_ADD;
            r_trial     <= '0;
            r_pw_src    <= RI_A;
            r_pw_half   <= 1'b0;
            r_ret       <= S_IDLE;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_cmd       <= n_cmd;
            r_trial     <= n_trial;
            r_pw_src    <= n_pw_src;
            r_pw_half   <= n_pw_half;
            r_ret       <= n_ret;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_cmd.op != OP_MUL)
        else $error("multiply issued while multiplier busy");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> r_busy)
        else $error("multiplier done without pending multiply");

    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_busy)
        else $error("ready while multiply pending");

    a_trial_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trial <= TW'(MAX_TRIALS - 1))
        else $error("trial counter beyond cap");

endmodule
`default_nettype wire

>>> tb/tb_prime_field_arith_sqrt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_field_arith_sqrt_unit: self-checking bench of the prime field unit
// Sends a directed set and then random transactions under several moduli, from
// degenerate ones up to 2^31-1. Each result is checked against an in-bench
// field model. Both sides stall at random but for one stretch without stalls.
// ----------------------------------------------------------------------------
module tb_prime_field_arith_sqrt_unit;
    import pfa_pkg::*;

    localparam int  TRIAL_CAP   = 64;
    localparam int  VW          = 31;
    localparam int  CYCLE_LIMIT = 40_000_000;
    localparam int  DRAIN_WAIT  = 200;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [30:0] opa;
        logic [30:0] opb;
        logic [30:0] start;
    } field_op_t;

    typedef struct {
        logic [VW-1:0] value;
        logic          ok;
    } field_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    pfa_in_if       in_ch ();
    pfa_out_if #(VW) out_ch ();

    prime_field_arith_sqrt_unit #(
        .MAX_TRIALS (TRIAL_CAP),
        .VALUE_WIDTH(VW)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_res      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    field_op_t  op_pending[$];
    field_res_t res_expected[$];
    field_op_t  op_on_bus;
    u64_t       field_mod;
    bit         no_stall;
    int         err_count;
    int         res_count;
    int         cycle_count;

    // ------------------------------------------------------------------
    // field model
    // ------------------------------------------------------------------
    function automatic u64_t mul_mod(u64_t a, u64_t b, u64_t m);
        return (a * b) % m;
    endfunction

    function automatic u64_t pow_mod(u64_t base, u64_t e, u64_t m);
        u64_t acc;
        acc = 1 % m;
        while (e != 0) begin
            if (e[0])
                acc = mul_mod(acc, base, m);
            base = mul_mod(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // (p0 + p1 x)(q0 + q1 x) with x^2 = y
    function automatic void ring_mul(inout u64_t p0, inout u64_t p1, input u64_t q0,
                                     input u64_t q1, input u64_t y, input u64_t m);
        u64_t c0;
        u64_t c1;
        c0 = (mul_mod(p0, q0, m) + mul_mod(mul_mod(p1, q1, m), y, m)) % m;
        c1 = (mul_mod(p0, q1, m) + mul_mod(p1, q0, m)) % m;
        p0 = c0;
        p1 = c1;
    endfunction

    // returns 1 when a root was found
    function automatic bit field_sqrt(input u64_t a, input u64_t start, input u64_t m,
                                      output u64_t root);
        u64_t half;
        u64_t z;
        u64_t r0, r1, b0, b1, e;
        half  = (m - 1) / 2;
        z     = start;
        root  = 0;
        if (a == 0)
            return 1'b1;
        if (pow_mod(a, half, m) != 1 % m)
            return 1'b0;
        for (int t = 0; t < TRIAL_CAP; t++) begin
            r0 = 1 % m;
            r1 = 0;
            b0 = z;
            b1 = 1 % m;
            e  = half;
            if (mul_mod(z, z, m) == a) begin
                root = z;
                return 1'b1;
            end
            while (e != 0) begin
                if (e[0])
                    ring_mul(r0, r1, b0, b1, a, m);
                ring_mul(b0, b1, b0, b1, a, m);
                e = e >> 1;
            end
            if (r1 != 0) begin
                root = pow_mod(r1, m - 2, m);
                return 1'b1;
            end
            z = z + 1;
            if (z >= m)
                z = 0;
        end
        return 1'b0;
    endfunction

    function automatic field_res_t predict_field_op(field_op_t op, u64_t m);
        field_res_t r;
        u64_t a, b, s, v;
        bit ok;
        v  = 0;
        ok = 0;
        if (m >= 2) begin
            a  = u64_t'(op.opa) % m;
            b  = u64_t'(op.opb) % m;
            s  = u64_t'(op.start) % m;
            ok = 1;
            case (op.cmd)
                CMD_ADD:  v = (a + b) % m;
                CMD_SUB:  v = (a + m - b) % m;
                CMD_NEG:  v = (m - a) % m;
                CMD_MUL:  v = mul_mod(a, b, m);
                CMD_INV:  v = pow_mod(a, m - 2, m);
                CMD_DIV:  v = mul_mod(a, pow_mod(b, m - 2, m), m);
                CMD_SQRT: ok = field_sqrt(a, s, m, v);
                default:  ok = 0;
            endcase
            if (!ok)
                v = 0;
        end
        r.value = v[VW-1:0];
        r.ok    = ok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, res_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver: one transaction at a time from op_pending
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                res_expected.push_back(predict_field_op(op_on_bus, field_mod));
            if (!in_ch.valid || in_ch.ready) begin
                if (op_pending.size() > 0 && (no_stall || $urandom_range(99) >= 22)) begin
                    op_on_bus = op_pending.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.cmd         <= op_on_bus.cmd;
                    in_ch.operand_a   <= op_on_bus.opa;
                    in_ch.operand_b   <= op_on_bus.opb;
                    in_ch.trial_start <= op_on_bus.start;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure, compare against oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        field_res_t exp_r;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                res_count <= res_count + 1;
                if (res_expected.size() == 0) begin
                    $error("unexpected result value=%0d ok=%0b", out_ch.value, out_ch.ok);
                    err_count = err_count + 1;
                end else begin
                    exp_r = res_expected.pop_front();
                    if (out_ch.value !== exp_r.value) begin
                        $error("value: expected %0d, actual %0d", exp_r.value, out_ch.value);
                        err_count = err_count + 1;
                    end
                    if (out_ch.ok !== exp_r.ok) begin
                        $error("ok: expected %0b, actual %0b", exp_r.ok, out_ch.ok);
                        err_count = err_count + 1;
                    end
                end
            end
            out_ch.ready <= no_stall || ($urandom_range(99) >= 22);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_op(logic [2:0] cmd, u64_t a, u64_t b, u64_t s);
        field_op_t op;
        op.cmd   = cmd;
        op.opa   = a[30:0];
        op.opb   = b[30:0];
        op.start = s[30:0];
        op_pending.push_back(op);
    endtask

    task automatic wait_idle();
        while (op_pending.size() != 0 || in_ch.valid || res_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(u64_t m);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m[30:0];
        field_mod  = m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly reduced elements, with edges and unreduced raw values
    function automatic u64_t rand_elem(u64_t m);
        u64_t raw;
        raw = u64_t'($urandom()) & 64'h7FFF_FFFF;
        if (m < 2)
            return raw;
        case ($urandom_range(7))
            0:       return raw;
            1:       return 0;
            2:       return m - 1;
            default: return raw % m;
        endcase
    endfunction

    task automatic random_phase(u64_t m, int count, bit sqrt_ok);
        logic [2:0] cmd;
        u64_t a, x;
        for (int i = 0; i < count; i++) begin
            cmd = 3'($urandom_range(sqrt_ok ? 6 : 5));
            a   = rand_elem(m);
            // sqrt: mostly squares so the candidate search runs
            if (cmd == CMD_SQRT && m >= 2 && $urandom_range(9) < 6) begin
                x = rand_elem(m) % m;
                a = (x * x) % m;
            end
            add_op(cmd, a, rand_elem(m), rand_elem(m));
        end
    endtask

    localparam u64_t M_RST = 998244353;
    localparam u64_t M_MAX = 64'h7FFF_FFFF;

    initial begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd   = '0;
        in_ch.operand_a   = '0;
        in_ch.operand_b   = '0;
        in_ch.trial_start = '0;
        out_ch.ready = 1'b0;
        field_mod   = M_RST;
        no_stall    = 1'b0;
        err_count   = 0;
        res_count   = 0;
        cycle_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset modulus
        add_op(CMD_ADD,  M_RST - 1, M_RST - 1, 0);
        add_op(CMD_SUB,  0, M_RST - 1, 0);
        add_op(CMD_NEG,  0, 0, 0);
        add_op(CMD_NEG,  M_MAX, 0, 0);
        add_op(CMD_MUL,  M_MAX, M_MAX, M_MAX);
        add_op(CMD_INV,  0, 0, 0);
        add_op(CMD_INV,  M_RST - 1, 0, 0);
        add_op(CMD_DIV,  12345, 0, 0);
        add_op(CMD_DIV,  M_RST - 2, 3, 0);
        add_op(CMD_SQRT, 0, 0, 0);
        add_op(CMD_SQRT, 3, 0, 0);
        add_op(CMD_SQRT, 4, 0, 2);
        add_op(CMD_SQRT, 2, M_MAX, M_MAX);
        wait_idle();

        // modulus below two
        write_modulus(0);
        add_op(CMD_ADD, 5, 6, 0);
        add_op(CMD_SQRT, 1, 0, 0);
        write_modulus(1);
        add_op(CMD_INV, M_MAX, 0, 0);

        // smallest field, inverse of zero is one there
        write_modulus(2);
        add_op(CMD_INV, 0, 0, 0);
        add_op(CMD_SQRT, 1, 0, 1);
        random_phase(2, 6, 1);

        // largest modulus, long stretch without stalls
        write_modulus(M_MAX);
        no_stall = 1'b1;
        add_op(CMD_SUB, 0, M_MAX - 1, 0);
        random_phase(M_MAX, 12, 1);
        wait_idle();
        no_stall = 1'b0;

        write_modulus(M_RST);
        random_phase(M_RST, 12, 1);
        write_modulus(13);
        random_phase(13, 10, 1);
        // composite moduli: small ones may exhaust the candidate cap
        write_modulus(15);
        random_phase(15, 10, 1);
        write_modulus(21);
        random_phase(21, 8, 1);
        write_modulus(M_MAX - 1);
        random_phase(M_MAX - 1, 10, 0);
        write_modulus(1000003);
        random_phase(1000003, 8, 1);
        write_modulus(3);
        random_phase(3, 8, 1);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d results over moduli from 0 to 2^31-1, all commands", res_count);
        $display("including sqrt zero, non-residues, candidate cap and degenerate moduli");
        if (err_count == 0 && res_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
